/* src/descending_sorted_list_core_defines.svh */
// Assertion macros for the one file that carries concurrent checks.
`ifndef DESCENDING_SORTED_LIST_CORE_DEFINES_SVH
`define DESCENDING_SORTED_LIST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed: ante implies cons");

// Next-cycle implication, disabled while reset is asserted.
`define DSL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed: ante implies cons in the next cycle");

`endif

/* src/dsl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dsl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FWD    = 2'd1;
  localparam logic [1:0] ACT_BWD    = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic                    ins_en;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* src/dsl_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dsl_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic signed [dsl_pkg::VAL_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

`default_nettype wire

/* src/dsl_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dsl_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [dsl_pkg::VAL_W-1:0] out_value;
  logic [1:0]                     status;
  logic                           last;

  modport source (output valid, out_value, status, last, input ready);
  modport sink   (input valid, out_value, status, last, output ready);
endinterface

`default_nettype wire

/* src/dsl_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module dsl_cell (
  input  wire logic                             clk,
  input  wire dsl_pkg::cell_ctl_t               ctl,
  input  wire logic [dsl_pkg::IDX_W-1:0]        idx,
  input  wire logic [dsl_pkg::CNT_W-1:0]        count,
  input  wire logic                             prev_ge,
  input  wire logic signed [dsl_pkg::VAL_W-1:0] prev_value,
  output logic                                  ge,
  output logic signed [dsl_pkg::VAL_W-1:0]      entry
);
  import dsl_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic                    occupied;

  // An occupied cell whose value is not below the new one keeps its place.
  assign occupied = CNT_W'(idx) < count;
  assign ge       = occupied && (entry_r >= ctl.value);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && !ge) begin
      entry_nxt = prev_ge ? ctl.value : prev_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

/* src/descending_sorted_list_core.sv */
// Keeps up to CAPACITY signed 32-bit values in descending order in a row of
// cells, with equal values in arrival order. On an insert every cell compares
// its value with the new one in parallel and the cells below the insertion
// point shift down by one, so inserts are accepted back to back while their
// result beats are taken. An insert into a full store is dropped with full
// status. A read streams the stored values one beat per cycle while the output
// is ready, largest first for a forward read and smallest first for a backward
// read, with last set on the final beat; no new item is accepted until a read
// has loaded its last beat, and a read of an empty store returns a single beat
// with empty status. While a result beat waits in the output register, the
// next item is accepted only in the cycle in which that beat is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "descending_sorted_list_core_defines.svh"

module descending_sorted_list_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dsl_in_if.sink     in_ch,
  dsl_out_if.source  out_ch
);
  import dsl_pkg::*;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [CNT_W-1:0]        rd_left_r;
  logic [CNT_W-1:0]        rd_left_nxt;
  logic [IDX_W-1:0]        rd_idx_r;
  logic [IDX_W-1:0]        rd_idx_nxt;
  logic                    rd_dir_r;
  logic                    rd_dir_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r;
  logic [1:0]              status_r;
  logic                    last_r;

  logic                    out_free;
  logic                    in_fire;
  logic                    load;
  logic signed [VAL_W-1:0] ld_value;
  logic [1:0]              ld_status;
  logic                    ld_last;
  cell_ctl_t               cell_ctl;
  logic                    left_chk;
  logic                    grow_chk;

  logic                    ge_w    [CAPACITY];
  logic signed [VAL_W-1:0] entry_w [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    prev_ge;
    logic signed [VAL_W-1:0] prev_value;

    if (g == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_value = cell_ctl.value;
    end else begin : g_body
      assign prev_ge    = ge_w[g-1];
      assign prev_value = entry_w[g-1];
    end

    dsl_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .idx        (IDX_W'(g)),
      .count      (count_r),
      .prev_ge    (prev_ge),
      .prev_value (prev_value),
      .ge         (ge_w[g]),
      .entry      (entry_w[g])
    );
  end

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.status    = status_r;
  assign out_ch.last      = last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.action == ACT_FWD || in_ch.action == ACT_BWD) &&
            count_r != '0) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (out_free && rd_left_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt       = count_r;
    rd_left_nxt     = rd_left_r;
    rd_idx_nxt      = rd_idx_r;
    rd_dir_nxt      = rd_dir_r;
    load            = 1'b0;
    ld_value        = '0;
    ld_status       = STAT_OK;
    ld_last         = 1'b1;
    cell_ctl.ins_en = 1'b0;
    cell_ctl.value  = in_ch.value;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.action)
            ACT_INSERT: begin
              load = 1'b1;
              if (count_r == CNT_W'(CAPACITY)) begin
                ld_status = STAT_FULL;
              end else begin
                cell_ctl.ins_en = 1'b1;
                count_nxt       = count_r + CNT_W'(1);
              end
            end
            ACT_FWD, ACT_BWD: begin
              if (count_r == '0) begin
                load      = 1'b1;
                ld_status = STAT_EMPTY;
              end else begin
                rd_left_nxt = count_r;
                rd_dir_nxt  = (in_ch.action == ACT_BWD);
                rd_idx_nxt  = (in_ch.action == ACT_BWD) ?
                              IDX_W'(count_r - CNT_W'(1)) : '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load        = 1'b1;
          ld_value    = entry_w[rd_idx_r];
          ld_last     = (rd_left_r == CNT_W'(1));
          rd_left_nxt = rd_left_r - CNT_W'(1);
          rd_idx_nxt  = rd_dir_r ? rd_idx_r - IDX_W'(1) : rd_idx_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_left_r   <= '0;
      rd_dir_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_left_r   <= rd_left_nxt;
      rd_dir_r    <= rd_dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    if (load) begin
      out_value_r <= ld_value;
      status_r    <= ld_status;
      last_r      <= ld_last;
    end
  end

  assign left_chk = (rd_left_r != '0) && (rd_left_r <= count_r);
  assign grow_chk = in_fire && (in_ch.action == ACT_INSERT) && (count_r < CNT_W'(CAPACITY));

  `DSL_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `DSL_ASSERT_IMP(a_read_left, clk, rst_n, state_r == S_READ, left_chk)
  `DSL_ASSERT_NXT(a_insert_grows, clk, rst_n, grow_chk, count_r == $past(count_r) + CNT_W'(1))

endmodule

`default_nettype wire

/* verif/tb_descending_sorted_list_core.sv */
`timescale 1ns / 1ps

module tb_descending_sorted_list_core;
  import dsl_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 150;
  localparam int         STALL_LIMIT  = 5000;
  localparam int         DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
    logic                    last;
  } beat_t;

  class descending_list_checker;
    logic signed [VAL_W-1:0] entries [CAPACITY];
    int    entry_count;
    beat_t pending_beats [$];
    int    errors;
    int    n_inserts;
    int    n_full;
    int    n_reads;
    int    n_empty;
    int    n_beats;

    function new();
      entry_count = 0;
      errors      = 0;
      n_inserts   = 0;
      n_full      = 0;
      n_reads     = 0;
      n_empty     = 0;
      n_beats     = 0;
    endfunction

    function void add_beat(logic signed [VAL_W-1:0] v, logic [1:0] st, logic lst);
      beat_t b;
      b.value  = v;
      b.status = st;
      b.last   = lst;
      pending_beats.push_back(b);
    endfunction

    // Works out the beats that one accepted input beat causes and updates the store.
    function void note_input(logic [1:0] act, logic signed [VAL_W-1:0] val);
      int pos;
      int idx;
      case (act)
        ACT_INSERT: begin
          if (entry_count >= CAPACITY) begin
            n_full++;
            add_beat('0, STAT_FULL, 1'b1);
          end else begin
            pos = 0;
            while (pos < entry_count && entries[pos] >= val) pos++;
            for (int i = entry_count; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = val;
            entry_count++;
            n_inserts++;
            add_beat('0, STAT_OK, 1'b1);
          end
        end
        ACT_FWD, ACT_BWD: begin
          n_reads++;
          if (entry_count == 0) begin
            n_empty++;
            add_beat('0, STAT_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < entry_count; i++) begin
              idx = (act == ACT_FWD) ? i : entry_count - 1 - i;
              add_beat(entries[idx], STAT_OK, i == entry_count - 1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(beat_t got);
      beat_t exp;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: out_value %0d status %0d last %0d",
               got.value, got.status, got.last);
        errors++;
        return;
      end
      exp = pending_beats.pop_front();
      n_beats++;
      if (got.value !== exp.value) begin
        $error("out_value: expected %0d, actual %0d", exp.value, got.value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, actual %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   burst_left;
  int   idle_cycles;

  dsl_in_if  in_ch ();
  dsl_out_if out_ch ();

  descending_list_checker sb = new();

  descending_sorted_list_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    bit took;
    beat_t got;
    took = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.action, in_ch.value);
        took = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.value  = out_ch.out_value;
        got.status = out_ch.status;
        got.last   = out_ch.last;
        sb.check_result(got);
        took = 1'b1;
      end
      idle_cycles <= took ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("no beat moved for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : receiver
    int mode;
    int span;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          2: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = (i % 5 == 0);
        endcase
      end
    end
  end

  task automatic send_beat(input logic [1:0] act, input logic signed [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.value  = val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: begin
        if (sb.entry_count > 0) return sb.entries[$urandom_range(0, sb.entry_count - 1)];
        return $urandom;
      end
      4: return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int counted;
    int pick;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.value  = '0;
    burst_left   = 0;
    rst_n        = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reads of the empty store, an unused action code, extreme values and ties.
    send_beat(ACT_FWD, 32'sd5);
    send_beat(ACT_BWD, -32'sd5);
    send_beat(ACT_UNUSED, 32'sd7);
    send_beat(ACT_INSERT, 32'sd0);
    send_beat(ACT_FWD, '0);
    send_beat(ACT_INSERT, 32'sh7fffffff);
    send_beat(ACT_INSERT, 32'sh80000000);
    send_beat(ACT_INSERT, 32'sd0);
    send_beat(ACT_INSERT, -32'sd1);
    send_beat(ACT_INSERT, 32'sd1);
    send_beat(ACT_INSERT, 32'sh7fffffff);
    send_beat(ACT_INSERT, 32'sh80000000);
    send_beat(ACT_UNUSED, -32'sd1);
    send_beat(ACT_FWD, '0);
    send_beat(ACT_BWD, '1);

    // Random inserts, reads, unused codes; the store fills and later inserts drop.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        send_beat(ACT_INSERT, pick_value());
        counted++;
      end else if (pick < 6) begin
        send_beat(ACT_FWD, $urandom);
        counted++;
      end else if (pick < 9) begin
        send_beat(ACT_BWD, $urandom);
        counted++;
      end else begin
        send_beat(ACT_UNUSED, $urandom);
      end
    end
    in_ch.valid = 1'b0;

    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d stored inserts, %0d dropped on a full store, %0d reads",
             sb.n_inserts, sb.n_full, sb.n_reads);
    $display("%0d reads found the store empty; %0d result beats checked",
             sb.n_empty, sb.n_beats);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
